>>> hw/rtl/lzssw_pkg.sv
package lzssw_pkg;

  localparam int unsigned DATA_W = 16;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

endpackage

>>> hw/rtl/lzssw_ram.sv
module lzssw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/lzss_word_encoder.sv
// Operation: a token is coded after 17 words are held; one search scans the
//   whole ring with one ring read and one window compare per cycle, then
//   shifts the token out bit by bit while the output can take it. A final
//   beat drains up to 17 tokens. No input is taken during a search or while
//   a token is shifted out. Output words leave through a one-word register.
// Reset: async, active low; then a clearing pass that zeroes the ring with
//   in_ready_o low. The same pass runs after every final beat.
module lzss_word_encoder #(
  parameter int unsigned WINDOW_BITS = 11,
  parameter int unsigned LENGTH_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] in_word_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_word_o,
  output logic        out_last_o
);

  localparam int unsigned WB   = WINDOW_BITS;
  localparam int unsigned LB   = LENGTH_BITS;
  localparam int unsigned N    = 1 << WB;
  localparam int unsigned LOOK = (1 << LB) + 1;
  localparam int unsigned SPAN = N - LOOK;
  localparam int unsigned CW   = $clog2(LOOK + 1);
  localparam int unsigned DW   = lzssw_pkg::DATA_W;
  localparam int unsigned MTW  = 1 + WB + LB;
  localparam int unsigned TOKW = (MTW > DW + 1) ? MTW : DW + 1;
  localparam int unsigned TLW  = $clog2(TOKW + 1);

  lzssw_pkg::state_e state_q, state_d;

  logic [WB-1:0]   wp_q, wp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [DW-1:0]   acc_q, acc_d;
  logic [3:0]      pend_q, pend_d;
  logic [DW-1:0]   look_q [LOOK];
  logic [DW-1:0]   look_d [LOOK];
  logic [DW-1:0]   cand_q [LOOK];
  logic [DW-1:0]   cand_d [LOOK];
  logic [WB-1:0]   clr_q, clr_d;
  logic [WB-1:0]   rdn_q, rdn_d;
  logic            rdv_q, rdv_d;
  logic            fresh_q, fresh_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [WB-1:0]   cpos_q, cpos_d;
  logic [CW-1:0]   blen_q, blen_d;
  logic [WB-1:0]   bpos_q, bpos_d;
  logic [TOKW-1:0] tok_q, tok_d;
  logic [TLW-1:0]  tlen_q, tlen_d;
  logic            final_q, final_d;
  logic            ov_q, ov_d;
  logic [DW-1:0]   ow_q, ow_d;
  logic            ol_q, ol_d;

  logic          ram_we;
  logic [WB-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] mlen;
  logic          run;
  logic [CW-1:0] adv;
  logic          in_beat, can_put, bit_v, start_scan;
  logic [DW-1:0] acc_n;

  lzssw_ram #(.WIDTH(DW), .DEPTH(N)) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o  = (state_q == lzssw_pkg::ST_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;
  assign out_last_o  = ol_q;
  assign can_put     = !ov_q || out_ready_i;
  assign bit_v       = tok_q[TOKW-1];
  assign acc_n       = {acc_q[DW-2:0], bit_v};

  assign ram_we    = in_beat || (state_q == lzssw_pkg::ST_CLEAR);
  assign ram_waddr = (state_q == lzssw_pkg::ST_CLEAR) ? clr_q : wp_q + WB'(cnt_q);
  assign ram_wdata = (state_q == lzssw_pkg::ST_CLEAR) ? '0 : in_word_i;
  assign ram_raddr = wp_q + WB'(LOOK) + rdn_q;

  always_comb begin
    mlen = '0;
    run  = 1'b1;
    for (int k = 0; k < LOOK; k++) begin
      if (run && (CW'(k) < cnt_q) && (cand_q[k] == look_q[k])) begin
        mlen = CW'(k + 1);
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    look_d  = look_q;
    cand_d  = cand_q;
    clr_d   = clr_q;
    rdn_d   = rdn_q;
    rdv_d   = 1'b0;
    fresh_d = 1'b0;
    fill_d  = fill_q;
    cpos_d  = cpos_q;
    blen_d  = blen_q;
    bpos_d  = bpos_q;
    tok_d   = tok_q;
    tlen_d  = tlen_q;
    final_d = final_q;
    ov_d    = ov_q && !out_ready_i;
    ow_d    = ow_q;
    ol_d    = ol_q;
    adv     = '0;
    start_scan = 1'b0;

    unique case (state_q)
      lzssw_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == WB'(N - 1)) begin
          state_d = lzssw_pkg::ST_IDLE;
        end
      end
      lzssw_pkg::ST_IDLE: begin
        if (in_beat) begin
          for (int k = 0; k < LOOK; k++) begin
            if (CW'(k) == cnt_q) begin
              look_d[k] = in_word_i;
            end
          end
          cnt_d = cnt_q + 1'b1;
          if (in_last_i) begin
            final_d    = 1'b1;
            start_scan = 1'b1;
          end else if (cnt_q == CW'(LOOK - 1)) begin
            start_scan = 1'b1;
          end
        end
      end
      lzssw_pkg::ST_SCAN: begin
        if (rdn_q != WB'(N - 1)) begin
          rdn_d = rdn_q + 1'b1;
          rdv_d = 1'b1;
        end
        if (rdv_q) begin
          for (int k = 0; k < LOOK - 1; k++) begin
            cand_d[k] = cand_q[k+1];
          end
          cand_d[LOOK-1] = ram_rdata;
          if (fill_q == CW'(LOOK)) begin
            cpos_d = cpos_q + 1'b1;
          end else begin
            fill_d = fill_q + 1'b1;
          end
          fresh_d = (fill_q >= CW'(LOOK - 1));
        end
        if (fresh_q) begin
          if (mlen >= CW'(2) && mlen >= blen_q) begin
            blen_d = mlen;
            bpos_d = cpos_q;
          end
          if (cpos_q == wp_q - 1'b1) begin
            adv = (blen_d < CW'(2)) ? CW'(1) : blen_d;
            if (blen_d < CW'(2)) begin
              tok_d  = TOKW'({1'b1, look_q[0]}) << (TOKW - DW - 1);
              tlen_d = TLW'(DW + 1);
            end else begin
              tok_d  = TOKW'({1'b0, bpos_d, LB'(blen_d - CW'(2))}) << (TOKW - MTW);
              tlen_d = TLW'(MTW);
            end
            for (int k = 0; k < LOOK; k++) begin
              for (int m = k + 1; m < LOOK; m++) begin
                if (CW'(m - k) == adv) begin
                  look_d[k] = look_q[m];
                end
              end
            end
            cnt_d   = cnt_q - adv;
            wp_d    = wp_q + WB'(adv);
            state_d = lzssw_pkg::ST_EMIT;
          end
        end
      end
      lzssw_pkg::ST_EMIT: begin
        if (can_put) begin
          tok_d  = tok_q << 1;
          tlen_d = tlen_q - 1'b1;
          if (pend_q == 4'd15) begin
            acc_d  = '0;
            pend_d = '0;
            ov_d   = 1'b1;
            ow_d   = acc_n;
            ol_d   = final_q && (tlen_q == TLW'(1)) && (cnt_q == '0);
          end else begin
            acc_d  = acc_n;
            pend_d = pend_q + 1'b1;
          end
          if (tlen_q == TLW'(1)) begin
            if (!final_q) begin
              state_d = lzssw_pkg::ST_IDLE;
            end else if (cnt_q == '0) begin
              state_d = lzssw_pkg::ST_FLUSH;
            end else begin
              start_scan = 1'b1;
            end
          end
        end
      end
      lzssw_pkg::ST_FLUSH: begin
        if (pend_q == '0 || can_put) begin
          if (pend_q != '0) begin
            ov_d = 1'b1;
            ow_d = acc_q << (5'd16 - {1'b0, pend_q});
            ol_d = 1'b1;
          end
          acc_d   = '0;
          pend_d  = '0;
          wp_d    = WB'(SPAN);
          cnt_d   = '0;
          final_d = 1'b0;
          clr_d   = '0;
          state_d = lzssw_pkg::ST_CLEAR;
        end
      end
      default: state_d = lzssw_pkg::ST_CLEAR;
    endcase

    if (start_scan) begin
      state_d = lzssw_pkg::ST_SCAN;
      rdn_d   = '0;
      rdv_d   = 1'b0;
      fresh_d = 1'b0;
      fill_d  = '0;
      cpos_d  = wp_q + WB'(LOOK);
      blen_d  = CW'(1);
      bpos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzssw_pkg::ST_CLEAR;
      wp_q    <= WB'(SPAN);
      cnt_q   <= '0;
      acc_q   <= '0;
      pend_q  <= '0;
      clr_q   <= '0;
      rdn_q   <= '0;
      rdv_q   <= 1'b0;
      fresh_q <= 1'b0;
      fill_q  <= '0;
      tlen_q  <= '0;
      final_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
      rdn_q   <= rdn_d;
      rdv_q   <= rdv_d;
      fresh_q <= fresh_d;
      fill_q  <= fill_d;
      tlen_q  <= tlen_d;
      final_q <= final_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    look_q <= look_d;
    cand_q <= cand_d;
    cpos_q <= cpos_d;
    blen_q <= blen_d;
    bpos_q <= bpos_d;
    tok_q  <= tok_d;
    ow_q   <= ow_d;
    ol_q   <= ol_d;
  end

endmodule

>>> hw/rtl/lzssw_checker.sv
module lzssw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [15:0] in_word_i,
  input logic        in_last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] out_word_o,
  input logic        out_last_o
);

  // stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o) && $stable(out_last_o))
    else $error("output beat changed while stalled");

  // a final input beat always starts a drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_last_i |=> !in_ready_o)
    else $error("input taken during drain");

  // a final beat still blocks input after the drain has begun
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_last_i |=> ##1 !in_ready_o)
    else $error("drain ended too early");

  // clearing pass after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !in_ready_o)
    else $error("ready during clearing pass");

endmodule

bind lzss_word_encoder lzssw_checker u_lzssw_checker (.*);

>>> sim/tb_lzss_word_encoder.sv
module tb_lzss_word_encoder;

  localparam int unsigned RING_N = 2048;
  localparam int unsigned LOOK_N = 17;
  localparam int unsigned SPAN_N = RING_N - LOOK_N;
  localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] in_word_i;
  logic        in_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] out_word_o;
  logic        out_last_o;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } packed_word_t;

  logic [15:0]  hist [RING_N];
  int unsigned  wpos;
  int unsigned  held;
  logic [15:0]  acc;
  int unsigned  nbits;
  packed_word_t words_due [$];

  int unsigned     errors;
  longint unsigned cycles;
  bit              hold_off;
  bit              busy_bits;

  lzss_word_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .out_last_o (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_encoder();
    for (int k = 0; k < RING_N; k++) hist[k] = '0;
    wpos = SPAN_N;
    held = 0;
    acc = '0;
    nbits = 0;
  endfunction

  function automatic void push_bit(bit b);
    packed_word_t w;
    acc = {acc[14:0], b};
    nbits++;
    if (nbits == 16) begin
      w.word = acc;
      w.last = 1'b0;
      words_due.push_back(w);
      acc = '0;
      nbits = 0;
    end
  endfunction

  function automatic void code_token();
    int unsigned r;
    int unsigned best_len;
    int unsigned best_pos;
    int unsigned i;
    int unsigned j;
    int unsigned adv;
    r = wpos;
    best_len = 1;
    best_pos = 0;
    for (int unsigned d = 1; d <= SPAN_N; d++) begin
      i = (r - d) % RING_N;
      if (hist[i] == hist[r]) begin
        j = 1;
        while (j < held && hist[(i + j) % RING_N] == hist[(r + j) % RING_N]) j++;
        if (j > best_len) begin
          best_len = j;
          best_pos = i;
        end
      end
    end
    if (best_len < 2) begin
      push_bit(1'b1);
      for (int k = 15; k >= 0; k--) push_bit(hist[r][k]);
      adv = 1;
    end else begin
      push_bit(1'b0);
      for (int k = 10; k >= 0; k--) push_bit(best_pos[k]);
      for (int k = 3; k >= 0; k--) push_bit(4'(best_len - 2) >> k);
      adv = best_len;
    end
    wpos = (r + adv) % RING_N;
    held -= adv;
  endfunction

  function automatic void predict_words(logic [15:0] word, logic last);
    packed_word_t w;
    int unsigned before_n;
    before_n = words_due.size();
    hist[(wpos + held) % RING_N] = word;
    held++;
    if (!last) begin
      if (held >= LOOK_N) code_token();
    end else begin
      while (held > 0) code_token();
      if (nbits != 0) begin
        w.word = acc << (16 - nbits);
        w.last = 1'b0;
        words_due.push_back(w);
      end
      if (words_due.size() > before_n) words_due[words_due.size() - 1].last = 1'b1;
      clear_encoder();
    end
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // output checker
  always @(posedge clk_i) begin
    packed_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (words_due.size() == 0) begin
        $display("%0t unexpected beat: expected none actual word=%h last=%b",
                 $time, out_word_o, out_last_o);
        errors++;
      end else begin
        e = words_due.pop_front();
        if (out_word_o !== e.word) begin
          $display("%0t word: expected %h actual %h", $time, e.word, out_word_o);
          errors++;
        end
        if (out_last_o !== e.last) begin
          $display("%0t last: expected %b actual %b", $time, e.last, out_last_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if (busy_bits) out_ready_i <= ($urandom_range(0, 3) != 0);
    else out_ready_i <= 1'b1;
  end

  task automatic send_beat(logic [15:0] word, logic last);
    in_valid_i <= 1'b1;
    in_word_i  <= word;
    in_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_words(word, last);
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    logic [15:0] v [] = '{16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h8000,
                          16'h0001, 16'haaaa, 16'h5555};
    foreach (v[k]) send_beat(v[k], k == v.size() - 1);
    send_beat(16'h1234, 1'b1);
    drain();
  endtask

  task automatic test_long_match();
    for (int k = 0; k < 22; k++) send_beat(16'(16'h00ab + (k % 3)), k == 21);
    drain();
  endtask

  task automatic test_random_streams();
    int n;
    int alph;
    busy_bits = 1'b1;
    for (int s = 0; s < 6; s++) begin
      n = (s == 0) ? 40 : $urandom_range(3, 25);
      alph = $urandom_range(0, 2);
      for (int k = 0; k < n; k++) begin
        case (alph)
          0: send_beat(16'($urandom_range(0, 3)), k == n - 1);
          1: send_beat(16'($urandom), k == n - 1);
          default: send_beat(($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000, k == n - 1);
        endcase
      end
    end
    drain();
    busy_bits = 1'b0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (60000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 30; k++) send_beat(16'($urandom), k == 29);
    join
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    busy_bits = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    in_last_i = 1'b0;
    out_ready_i = 1'b1;
    clear_encoder();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_long_match();
    test_random_streams();
    test_backpressure();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
